### src/ssts_pkg.sv
`timescale 1ns / 1ps

package ssts_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 20;
	localparam int RANK_W = 4;

	// one slot of the ranked list
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         index;
		logic                     valid;
	} entry_t;

	// per-cycle command shared by every cell of the chain
	typedef struct packed {
		logic insert;    // place a new sample, lower entries move down
		logic shift_up;  // drain: every cell takes its lower neighbor
		logic clear;     // empty the list
	} cell_ctrl_t;

endpackage

### src/ssts_cell.sv
`timescale 1ns / 1ps

module ssts_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssts_pkg::cell_ctrl_t              ctrl,
	input  logic signed [ssts_pkg::DATA_W-1:0] sample,
	input  logic [ssts_pkg::POS_W-1:0]        sample_idx,
	input  ssts_pkg::entry_t                  prev_ent,
	input  logic                              prev_take,
	input  ssts_pkg::entry_t                  next_ent,
	output ssts_pkg::entry_t                  ent,
	output logic                              take
);
	import ssts_pkg::*;

	entry_t ent_q;

	// the new sample belongs at or above this slot
	assign take = !ent_q.valid || ($signed(sample) > $signed(ent_q.value));
	assign ent  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctrl.clear) begin
			ent_q.valid <= 1'b0;
		end else if (ctrl.insert) begin
			// upper neighbor already took the sample: move down
			if (prev_take) begin
				ent_q <= prev_ent;
			end else if (take) begin
				ent_q.value <= sample;
				ent_q.index <= sample_idx;
				ent_q.valid <= 1'b1;
			end
		end else if (ctrl.shift_up) begin
			ent_q <= next_ent;
		end
	end

endmodule

### src/ssts_div.sv
`timescale 1ns / 1ps

module ssts_div #(
	parameter int SW = 53,
	parameter int CW = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [SW-1:0] dividend,
	input  logic [CW-1:0]       divisor,
	output logic                done,
	output logic signed [31:0]  quotient
);
	import ssts_pkg::*;

	localparam int SCW = $clog2(SW + 1);
	localparam logic [SCW-1:0] STEPS = SCW'(SW);

	logic           busy_q;
	logic           done_q;
	logic           neg_q;
	logic [SCW-1:0] step_q;
	logic [CW-1:0]  rem_q;
	logic [SW-1:0]  quo_q;
	logic [SW-1:0]  mag;
	logic [CW:0]    trial;
	logic           fits;
	logic [SW-1:0]  res;

	// magnitude of the dividend, taken at start
	assign mag = dividend[SW-1] ? (~dividend + 1'b1) : dividend;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[SW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEPS;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SCW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			neg_q <= dividend[SW-1];
		end else if (busy_q) begin
			rem_q <= fits ? CW'(trial - {1'b0, divisor}) : CW'(trial);
			quo_q <= {quo_q[SW-2:0], fits};
		end
	end

	// restore the sign; the mean always fits 32 bits
	assign res      = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient = res[31:0];
	assign done     = done_q;

endmodule

### src/sample_stats_top_ten.sv
`timescale 1ns / 1ps

// Channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------------
// in       | in_valid / in_stall     | sample, last_sample
// out      | out_valid / out_stall   | rank, top_value, top_position, minimum,
//          |                         | maximum, mean, last_result
//
// Samples are taken one per cycle while in_stall is low; each beat taken below
// MAX_SAMPLES updates count, sum, min, max and the ranked cell chain in that same cycle.
// After the last-marked sample the mean comes from a bit-serial divider of
// 32 + clog2(MAX_SAMPLES+1) steps.
// Then TOP_COUNT result beats follow, one per cycle while out_stall is low;
// the chain shifts up one slot per delivered beat, and the final beat clears it.
// in_stall is high from the last sample until the final result beat is taken.
// Reset empties the list and clears count, sum, min and max; the mean is not reset.
module sample_stats_top_ten #(
	parameter int TOP_COUNT   = 10,
	parameter int MAX_SAMPLES = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sample,
	input  logic               last_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         rank,
	output logic signed [31:0] top_value,
	output logic [19:0]        top_position,
	output logic signed [31:0] minimum,
	output logic signed [31:0] maximum,
	output logic signed [31:0] mean,
	output logic               last_result
);
	import ssts_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = DATA_W + CW;
	localparam int RW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
	localparam logic [CW-1:0] CAP      = CW'(MAX_SAMPLES);
	localparam logic [RW-1:0] LAST_RNK = RW'(TOP_COUNT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic signed [SW-1:0]    sum_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] mean_q;
	logic [RW-1:0]           rank_q;
	logic                    div_start_q;

	logic                    in_acc;
	logic                    out_acc;
	logic                    room;
	logic                    div_done;
	logic signed [31:0]      div_quo;
	logic                    drain_end;
	cell_ctrl_t              ctrl;
	entry_t                  ents  [TOP_COUNT];
	logic                    takes [TOP_COUNT];

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign room      = count_q < CAP;
	assign drain_end = out_acc && (rank_q == LAST_RNK);

	// chain command for this cycle
	assign ctrl.insert   = in_acc && room;
	assign ctrl.shift_up = out_acc && !drain_end;
	assign ctrl.clear    = drain_end;

	// ranked list: cell 0 holds the largest value
	for (genvar g = 0; g < TOP_COUNT; g++) begin : g_cell
		entry_t p_ent;
		entry_t n_ent;
		logic   p_take;
		if (g == 0) begin : g_head
			assign p_ent  = '0;
			assign p_take = 1'b0;
		end else begin : g_mid
			assign p_ent  = ents[g-1];
			assign p_take = takes[g-1];
		end
		if (g == TOP_COUNT - 1) begin : g_tail
			assign n_ent = '0;
		end else begin : g_body
			assign n_ent = ents[g+1];
		end
		ssts_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample     (sample),
			.sample_idx (POS_W'(count_q)),
			.prev_ent   (p_ent),
			.prev_take  (p_take),
			.next_ent   (n_ent),
			.ent        (ents[g]),
			.take       (takes[g])
		);
	end

	ssts_div #(
		.SW (SW),
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer: collect, divide, drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			rank_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && last_sample) begin
						state_q     <= ST_DIV;
						div_start_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
						rank_q  <= '0;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						rank_q <= rank_q + 1'b1;
						if (drain_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (drain_end) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (in_acc && room) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + {{(SW-DATA_W){sample[DATA_W-1]}}, sample};
			if (count_q == '0) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				if (sample > max_q) max_q <= sample;
				if (sample < min_q) min_q <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			mean_q <= (count_q == '0) ? '0 : div_quo;
		end
	end

	// result beat from the head cell; empty slots and slots at the minimum read as the minimum
	always_comb begin
		if (ents[0].valid && (ents[0].value != min_q)) begin
			top_value    = ents[0].value;
			top_position = ents[0].index;
		end else begin
			top_value    = min_q;
			top_position = '0;
		end
	end

	assign rank        = RANK_W'(rank_q);
	assign minimum     = min_q;
	assign maximum     = max_q;
	assign mean        = mean_q;
	assign last_result = (rank_q == LAST_RNK);

endmodule

### sim/sample_stats_top_ten_tb.sv
`timescale 1ns / 1ps

module sample_stats_top_ten_tb;
	import ssts_pkg::DATA_W;
	import ssts_pkg::POS_W;
	import ssts_pkg::RANK_W;

	// list size and sample capacity at their default values
	localparam int TOP_N = 10;
	localparam int CAP   = 1048576;

	localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] VMIN = 32'sh80000000;

	// value styles for one data set
	typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_EDGES, STYLE_MIXED} value_style_e;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		int                       gap;
		bit                       hold;
	} sample_beat_t;

	typedef struct {
		logic [RANK_W-1:0]        rank;
		logic signed [DATA_W-1:0] top_value;
		logic [POS_W-1:0]         top_position;
		logic signed [DATA_W-1:0] minimum;
		logic signed [DATA_W-1:0] maximum;
		logic signed [DATA_W-1:0] mean;
		logic                     last_result;
	} ranking_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample      = '0;
	logic                     last_sample = 1'b0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic [RANK_W-1:0]        rank;
	logic signed [DATA_W-1:0] top_value;
	logic [POS_W-1:0]         top_position;
	logic signed [DATA_W-1:0] minimum;
	logic signed [DATA_W-1:0] maximum;
	logic signed [DATA_W-1:0] mean;
	logic                     last_result;

	// pending stimulus and expected ranking beats
	sample_beat_t feed_q[$];
	ranking_t     ranking_q[$];

	// shadow of the block's statistics
	int unsigned              tally;
	longint                   total;
	logic signed [DATA_W-1:0] lo;
	logic signed [DATA_W-1:0] hi;
	logic signed [DATA_W-1:0] slot_val[TOP_N];
	logic [POS_W-1:0]         slot_pos[TOP_N];
	bit                       slot_used[TOP_N];

	int errors        = 0;
	int samples_taken = 0;
	int sets_closed   = 0;
	int beats_checked = 0;

	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;

	sample_beat_t cur;
	bit           have_cur   = 0;
	int           stall_left = 0;
	bit           out_calm   = 0;

	sample_stats_top_ten #(
		.TOP_COUNT  (TOP_N),
		.MAX_SAMPLES(CAP)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rank        (rank),
		.top_value   (top_value),
		.top_position(top_position),
		.minimum     (minimum),
		.maximum     (maximum),
		.mean        (mean),
		.last_result (last_result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	// empty list and statistics
	task automatic clear_stats();
		int i;
		tally = 0;
		total = 0;
		lo    = '0;
		hi    = '0;
		for (i = 0; i < TOP_N; i++) begin
			slot_val[i]  = '0;
			slot_pos[i]  = '0;
			slot_used[i] = 0;
		end
	endtask

	// fold one sample into count, sum, min, max and the ranked list
	task automatic fold_sample(input logic signed [DATA_W-1:0] v);
		int j;
		int k;
		bit placed;
		if (tally < CAP) begin
			if (tally == 0) begin
				lo = v;
				hi = v;
			end else begin
				if (v > hi) hi = v;
				if (v < lo) lo = v;
			end
			total += v;
			placed = 0;
			for (j = 0; j < TOP_N; j++) begin
				if (!placed && (!slot_used[j] || v > slot_val[j])) begin
					for (k = TOP_N - 1; k > j; k--) begin
						slot_val[k]  = slot_val[k-1];
						slot_pos[k]  = slot_pos[k-1];
						slot_used[k] = slot_used[k-1];
					end
					slot_val[j]  = v;
					slot_pos[j]  = POS_W'(tally);
					slot_used[j] = 1;
					placed = 1;
				end
			end
			tally++;
		end
	endtask

	// queue the ten rank beats of a closed set, then start over
	task automatic emit_ranking();
		ranking_t r;
		longint   avg;
		int       i;
		avg = (tally != 0) ? total / longint'(tally) : 0;
		for (i = 0; i < TOP_N; i++) begin
			r.rank         = RANK_W'(i);
			r.top_value    = lo;
			r.top_position = '0;
			// empty slots and slots holding the minimum read as the minimum
			if (slot_used[i] && slot_val[i] != lo) begin
				r.top_value    = slot_val[i];
				r.top_position = slot_pos[i];
			end
			r.minimum     = lo;
			r.maximum     = hi;
			r.mean        = avg[DATA_W-1:0];
			r.last_result = (i == TOP_N - 1);
			ranking_q.push_back(r);
		end
		clear_stats();
	endtask

	task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			errors++;
		end
	endtask

	task automatic add_beat(input logic signed [DATA_W-1:0] v, input logic lst,
			input int gap, input bit hold);
		sample_beat_t b;
		b.value = v;
		b.last  = lst;
		b.gap   = gap;
		b.hold  = hold;
		feed_q.push_back(b);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input value_style_e style);
		value_style_e s;
		int           c;
		s = style;
		if (s == STYLE_MIXED) s = value_style_e'($urandom_range(0, 2));
		case (s)
			STYLE_WIDE: begin
				return $urandom;
			end
			STYLE_NARROW: begin
				return $signed(32'($urandom_range(0, 6))) - 3;
			end
			default: begin
				c = $urandom_range(0, 5);
				case (c)
					0: return VMIN;
					1: return VMAX;
					2: return VMIN + 1;
					3: return VMAX - 1;
					4: return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	// build every data set up front
	task automatic build_stimulus();
		int           i;
		int           len;
		int           n;
		bit           burst;
		value_style_e style;
		// set of one at the top extreme
		add_beat(VMAX, 1'b1, 0, 0);
		// extremes, ties and a repeated value closing the set
		add_beat(VMIN, 1'b0, 3, 0);
		add_beat(VMAX, 1'b0, 0, 0);
		add_beat(0, 1'b0, 0, 0);
		add_beat(-1, 1'b0, 5, 0);
		add_beat(1, 1'b0, 0, 0);
		add_beat(5, 1'b0, 0, 0);
		add_beat(5, 1'b0, 15, 0);
		add_beat(5, 1'b1, 0, 0);
		// negative mean truncates toward zero
		add_beat(-7, 1'b0, 0, 0);
		add_beat(-2, 1'b1, 0, 1);
		// all equal: every rank reads as the minimum
		add_beat(-3, 1'b0, 0, 0);
		add_beat(-3, 1'b0, 0, 0);
		add_beat(-3, 1'b1, 0, 0);
		// ascending past list size, early entries fall off the bottom
		for (i = 1; i <= TOP_N + 4; i++)
			add_beat(i, (i == TOP_N + 4), 0, 0);

		// random sets
		n = 0;
		while (n < 430) begin
			if ($urandom_range(0, 7) == 0) len = $urandom_range(TOP_N + 1, TOP_N + 8);
			else len = $urandom_range(1, 14);
			burst = ($urandom_range(0, 2) == 0);
			style = value_style_e'($urandom_range(0, 3));
			for (i = 0; i < len; i++) begin
				add_beat(pick_value(style), (i == len - 1),
					burst ? 0 : $urandom_range(0, 15),
					(i == 0) && (n == 0 || $urandom_range(0, 5) == 0));
			end
			n += len;
		end
	endtask

	// sender: one beat at a time, gap drawn per beat, optional drain hold
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (!have_cur && feed_q.size() > 0) begin
					cur      = feed_q.pop_front();
					have_cur = 1;
				end
				if (have_cur && cur.hold && ranking_q.size() != 0) begin
					in_valid <= 1'b0;
				end else if (have_cur && cur.gap > 0) begin
					cur.hold = 0;
					cur.gap--;
					in_valid <= 1'b0;
				end else if (have_cur) begin
					sample      <= cur.value;
					last_sample <= cur.last;
					in_valid    <= 1'b1;
					have_cur     = 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: drawn per result beat, with calm stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
				stall_left = out_calm ? 0 : $urandom_range(0, 15);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// check result beats, then fold accepted samples
	always @(posedge clk) begin : watch
		ranking_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (ranking_q.size() == 0) begin
					$error("result beat with no expectation pending");
					errors++;
				end else begin
					want = ranking_q.pop_front();
					compare_field("rank", 32'(want.rank), 32'(rank));
					compare_field("top_value", want.top_value, top_value);
					compare_field("top_position", 32'(want.top_position), 32'(top_position));
					compare_field("minimum", want.minimum, minimum);
					compare_field("maximum", want.maximum, maximum);
					compare_field("mean", want.mean, mean);
					compare_field("last_result", 32'(want.last_result), 32'(last_result));
					beats_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				fold_sample(sample);
				samples_taken++;
				if (last_sample) begin
					emit_ranking();
					sets_closed++;
				end
			end
			in_taken  <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
		end
	end

	initial begin
		clear_stats();
		build_stimulus();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (feed_q.size() != 0 || have_cur || in_valid)
			@(posedge clk);
		while (ranking_q.size() != 0)
			@(posedge clk);
		// divider plus drain, then some margin for stray beats
		repeat (80) @(posedge clk);
		$display("Fed %0d samples in %0d data sets (capacity %0d, list of %0d).",
			samples_taken, sets_closed, CAP, TOP_N);
		$display("Checked %0d rank beats, %0d field mismatches.", beats_checked, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
src/ssts_pkg.sv
src/ssts_cell.sv
src/ssts_div.sv
src/sample_stats_top_ten.sv
sim/sample_stats_top_ten_tb.sv
